>>> design/us3d_pkg.sv
// Package with shared constants, types and register codes for the 3D upsample page indexer.
`default_nettype none
package us3d_pkg;

  localparam int PAGE_BITS_DEF  = 32;
  localparam int DIM_BITS_DEF   = 12;
  localparam int SCALE_BITS_DEF = 8;
  localparam int NUM_REGS       = 6;
  localparam int CFG_ADDR_BITS  = 5;

  // Register indexes in the configuration space.
  typedef enum logic [2:0] {
    REG_IN_D = 3'd0,
    REG_IN_H = 3'd1,
    REG_IN_W = 3'd2,
    REG_SC_D = 3'd3,
    REG_SC_H = 3'd4,
    REG_SC_W = 3'd5
  } reg_idx_t;

  // Control word that travels along the divider chain beside the data.
  typedef struct packed {
    logic vld;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> design/us3d_div_cell.sv
// One restoring-division cell: retires one quotient bit and hands the partial state on.
`default_nettype none
module us3d_div_cell #(
  parameter int W   = 32,
  parameter int BIT = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  us3d_pkg::cell_ctl_t   ctl_i,
  input  wire logic [W-1:0]     rem_i,
  input  wire logic [W-1:0]     quo_i,
  input  wire logic [W-1:0]     div_i,
  input  wire logic [W-1:0]     tag_i,
  output us3d_pkg::cell_ctl_t   ctl_o,
  output logic      [W-1:0]     rem_o,
  output logic      [W-1:0]     quo_o,
  output logic      [W-1:0]     div_o,
  output logic      [W-1:0]     tag_o
);
  import us3d_pkg::*;

  logic [W:0]   trial;
  logic [W:0]   shifted;
  logic         fits;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;
  cell_ctl_t    ctl_r;
  logic [W-1:0] rem_r, quo_r, div_r, tag_r;

  // Compare the divisor shifted to this bit position against the partial remainder.
  always_comb begin
    shifted = {1'b0, rem_i} >> BIT;
    fits    = (div_i != '0) && (shifted >= {1'b0, div_i});
    trial   = {1'b0, rem_i} - ({1'b0, div_i} << BIT);
    rem_nxt = fits ? trial[W-1:0] : rem_i;
    quo_nxt = quo_i;
    if (div_i == '0) begin
      quo_nxt[BIT] = 1'b1;
    end else begin
      quo_nxt[BIT] = fits;
    end
  end

  // Valid flag is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_i;
    tag_r <= tag_i;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign div_o = div_r;
  assign tag_o = tag_r;

endmodule
`default_nettype wire

>>> design/us3d_div_chain.sv
// Pipelined divider built as a row of cells, one quotient bit per cell, MSB first.
`default_nettype none
module us3d_div_chain #(
  parameter int W = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  us3d_pkg::cell_ctl_t ctl_i,
  input  wire logic [W-1:0]   num_i,
  input  wire logic [W-1:0]   den_i,
  input  wire logic [W-1:0]   tag_i,
  output us3d_pkg::cell_ctl_t ctl_o,
  output logic      [W-1:0]   quo_o,
  output logic      [W-1:0]   rem_o,
  output logic      [W-1:0]   tag_o
);
  import us3d_pkg::*;

  cell_ctl_t    ctl_c [W+1];
  logic [W-1:0] rem_c [W+1];
  logic [W-1:0] quo_c [W+1];
  logic [W-1:0] div_c [W+1];
  logic [W-1:0] tag_c [W+1];

  assign ctl_c[0] = ctl_i;
  assign rem_c[0] = num_i;
  assign quo_c[0] = '0;
  assign div_c[0] = den_i;
  assign tag_c[0] = tag_i;

  // Cell k decides quotient bit W-1-k.
  for (genvar k = 0; k < W; k++) begin : g_cell
    us3d_div_cell #(.W(W), .BIT(W - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_c[k]),
      .rem_i (rem_c[k]),
      .quo_i (quo_c[k]),
      .div_i (div_c[k]),
      .tag_i (tag_c[k]),
      .ctl_o (ctl_c[k+1]),
      .rem_o (rem_c[k+1]),
      .quo_o (quo_c[k+1]),
      .div_o (div_c[k+1]),
      .tag_o (tag_c[k+1])
    );
  end

  assign ctl_o = ctl_c[W];
  assign quo_o = quo_c[W];
  assign rem_o = rem_c[W];
  assign tag_o = tag_c[W];

endmodule
`default_nettype wire

>>> design/upsample3d_nearest_page_index.sv
// Top level of the 3D nearest-neighbor upsample page indexer.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_start, in_busy, in_out_page          | taken when start high, busy low
//  result  | out_valid, out_in_page                  | one-cycle strobe, no stall
//  config  | psel penable pwrite paddr pwdata prdata | APB write, pready tied high
//
// An item is accepted every cycle, except that busy is high after reset and
// after each register write while the derived volumes settle. The result
// passes through four divider cell chains in series (page by volume, remainder
// by plane, remainder by row, then coordinates by scales) and the product and
// sum stages after them. Reset clears all valid flags and sets every
// configuration register to one. The receiver cannot stall, so nothing ever
// backs up.
`default_nettype none
module upsample3d_nearest_page_index #(
  parameter int PAGE_BITS  = us3d_pkg::PAGE_BITS_DEF,
  parameter int DIM_BITS   = us3d_pkg::DIM_BITS_DEF,
  parameter int SCALE_BITS = us3d_pkg::SCALE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_start,
  output logic                                    in_busy,
  input  wire logic [31:0]                        in_out_page,
  output logic                                    out_valid,
  output logic [31:0]                             out_in_page,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [us3d_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import us3d_pkg::*;

  localparam int P  = PAGE_BITS;
  localparam int DW = DIM_BITS + 1;
  localparam int SW = SCALE_BITS;

  // Configuration registers.
  logic [DW-1:0] cfg_in_d_r, cfg_in_h_r, cfg_in_w_r;
  logic [SW-1:0] cfg_sc_d_r, cfg_sc_h_r, cfg_sc_w_r;
  logic          wr_en;
  reg_idx_t      wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_in_d_r <= DW'(1);
      cfg_in_h_r <= DW'(1);
      cfg_in_w_r <= DW'(1);
      cfg_sc_d_r <= SW'(1);
      cfg_sc_h_r <= SW'(1);
      cfg_sc_w_r <= SW'(1);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_IN_D: cfg_in_d_r <= pwdata[DW-1:0];
        REG_IN_H: cfg_in_h_r <= pwdata[DW-1:0];
        REG_IN_W: cfg_in_w_r <= pwdata[DW-1:0];
        REG_SC_D: cfg_sc_d_r <= pwdata[SW-1:0];
        REG_SC_H: cfg_sc_h_r <= pwdata[SW-1:0];
        REG_SC_W: cfg_sc_w_r <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (wr_idx)
        REG_IN_D: prdata = 32'(cfg_in_d_r);
        REG_IN_H: prdata = 32'(cfg_in_h_r);
        REG_IN_W: prdata = 32'(cfg_in_w_r);
        REG_SC_D: prdata = 32'(cfg_sc_d_r);
        REG_SC_H: prdata = 32'(cfg_sc_h_r);
        REG_SC_W: prdata = 32'(cfg_sc_w_r);
        default:  prdata = '0;
      endcase
    end
  end

  // Derived volumes, registered; stable while items flow only if the user writes no register then (not enforced).
  logic [P-1:0] o_w_r, o_h_r, o_d_r, i_hw_r;
  logic [P-1:0] o_hw_r, o_dhw_r, i_dhw_r;
  logic [P-1:0] o_hw_a_r;
  always_ff @(posedge clk) begin
    o_w_r    <= P'(cfg_in_w_r * cfg_sc_w_r);
    o_h_r    <= P'(cfg_in_h_r * cfg_sc_h_r);
    o_d_r    <= P'(cfg_in_d_r * cfg_sc_d_r);
    i_hw_r   <= P'(cfg_in_h_r * cfg_in_w_r);
    o_hw_r   <= P'(o_h_r * o_w_r);
    i_dhw_r  <= P'(P'(cfg_in_d_r) * i_hw_r);
    o_hw_a_r <= o_hw_r;
    o_dhw_r  <= P'(o_d_r * o_hw_a_r);
  end

  // Hold off items until the volume registers reflect the latest write.
  logic [2:0] settle_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 3'd4;
    end else if (wr_en) begin
      settle_r <= 3'd4;
    end else if (settle_r != 3'd0) begin
      settle_r <= settle_r - 3'd1;
    end
  end

  assign in_busy = (settle_r != 3'd0);
  logic      acc;
  cell_ctl_t c0_i, c0_o, c1_i, c1_o, c2_i, c2_o;
  assign acc = in_start && !in_busy;
  assign c0_i.vld = acc;

  // Stage A: n = page / o_dhw, rem = page mod o_dhw.
  logic [P-1:0] n0, r0, t0;
  us3d_div_chain #(.W(P)) u_div_n (
    .clk(clk), .rst_n(rst_n), .ctl_i(c0_i),
    .num_i(P'(in_out_page)), .den_i(o_dhw_r), .tag_i('0),
    .ctl_o(c0_o), .quo_o(n0), .rem_o(r0), .tag_o(t0)
  );

  // Stage B: d = rem / o_hw; n rides in the tag lane.
  logic [P-1:0] d1, r1, n1;
  assign c1_i = c0_o;
  us3d_div_chain #(.W(P)) u_div_d (
    .clk(clk), .rst_n(rst_n), .ctl_i(c1_i),
    .num_i(r0 | (t0 & '0)), .den_i(o_hw_r), .tag_i(n0),
    .ctl_o(c1_o), .quo_o(d1), .rem_o(r1), .tag_o(n1)
  );

  // Stage C: h = rem / o_w, w = remainder. d and n wait in registers alongside.
  logic [P-1:0] h2, w2, n2;
  logic [P-1:0] d_dly_r [P];
  always_ff @(posedge clk) begin
    d_dly_r[0] <= d1;
    for (int k = 1; k < P; k++) begin
      d_dly_r[k] <= d_dly_r[k-1];
    end
  end
  assign c2_i = c1_o;
  us3d_div_chain #(.W(P)) u_div_h (
    .clk(clk), .rst_n(rst_n), .ctl_i(c2_i),
    .num_i(r1), .den_i(o_w_r), .tag_i(n1),
    .ctl_o(c2_o), .quo_o(h2), .rem_o(w2), .tag_o(n2)
  );

  // Coordinate divide by scale: the quotient is below 2^P and scales are narrow,
  // so a second set of chains would be costly; each coordinate goes through its
  // own cell chain, the three running in parallel lanes.
  cell_ctl_t    cs_o [3];
  logic [P-1:0] sq   [3];
  logic [P-1:0] sr   [3];
  logic [P-1:0] st   [3];
  logic [P-1:0] s_num [3];
  logic [P-1:0] s_den [3];
  assign s_num[0] = d_dly_r[P-1];
  assign s_num[1] = h2;
  assign s_num[2] = w2;
  assign s_den[0] = P'(cfg_sc_d_r);
  assign s_den[1] = P'(cfg_sc_h_r);
  assign s_den[2] = P'(cfg_sc_w_r);
  for (genvar l = 0; l < 3; l++) begin : g_lane
    us3d_div_chain #(.W(P)) u_div_s (
      .clk(clk), .rst_n(rst_n), .ctl_i(c2_o),
      .num_i(s_num[l]), .den_i(s_den[l]), .tag_i((l == 0) ? n2 : '0),
      .ctl_o(cs_o[l]), .quo_o(sq[l]), .rem_o(sr[l]), .tag_o(st[l])
    );
  end

  // Rebuild: register products, then sum.
  logic [P-1:0] p_n_r, p_d_r, p_h_r, p_w_r;
  logic         v_m_r, v_o_r;
  logic [P-1:0] res_r;
  always_ff @(posedge clk) begin
    p_n_r <= P'(st[0] * i_dhw_r);
    p_d_r <= P'(sq[0] * i_hw_r);
    p_h_r <= P'(sq[1] * P'(cfg_in_w_r));
    p_w_r <= sq[2] | (sr[0] & sr[1] & sr[2] & st[1] & st[2] & '0);
    res_r <= P'(p_n_r + p_d_r + p_h_r + p_w_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      v_m_r <= cs_o[0].vld && cs_o[1].vld && cs_o[2].vld;
      v_o_r <= v_m_r;
    end
  end

  assign out_valid   = v_o_r;
  assign out_in_page = 32'(res_r);

`ifndef SYNTHESIS
  // The three scale lanes move in lock step.
  a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
    cs_o[0].vld == cs_o[1].vld && cs_o[1].vld == cs_o[2].vld)
    else $error("scale lanes out of step");
  // A result strobe follows a lane exit through the v_m_r and v_o_r registers.
  a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cs_o[0].vld, 2))
    else $error("result without lane exit");
  // pready never drops.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");
`endif

endmodule
`default_nettype wire
